@@ rtl/ffba_pkg.sv @@
// Package: shared constants, codes and types of the block allocator.
package ffba_pkg;
  localparam int NUM_BLOCKS_DEF  = 256;
  localparam int BLOCK_BYTES_DEF = 4096;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_COUNT  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAG,
    S_SCAN,
    S_APPLY,
    S_OUT
  } state_t;

  // Command broadcast to every cell in a cycle.
  typedef struct packed {
    logic        clr;      // clear of used bit and tag
    logic        sel_tag;  // capture own tag on the lookup bus
    logic        do_free;  // clear used if tag matches key
    logic        do_mark;  // mark used and write tag if in marked range
  } cell_cmd_t;
endpackage

@@ rtl/ffba_if.sv @@
// Interfaces: valid/ready channels for requests, results and configuration.
interface ffba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] size_bytes;
  logic [31:0] address;
  logic [31:0] tag;
  modport source (output valid, operation, size_bytes, address, tag, input ready);
  modport sink   (input valid, operation, size_bytes, address, tag, output ready);
endinterface

interface ffba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [1:0]  status;
  logic [8:0]  block_count;
  modport source (output valid, result_address, status, block_count, input ready);
  modport sink   (input valid, result_address, status, block_count, output ready);
endinterface

interface ffba_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/ffba_cell.sv @@
// Cell: one block's used bit and tag, with shift stage for the scan chain.
module ffba_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ffba_pkg::cell_cmd_t cmd,
  input  logic                sel,       // this block is the addressed one
  input  logic [31:0]         key,
  input  logic                in_range,  // inside the range being marked
  input  logic [31:0]         new_tag,
  input  logic                load,      // load shift stage from used bit
  input  logic                shift,     // advance scan chain
  input  logic                sh_in,     // from upper neighbor
  output logic                sh_out,
  output logic [31:0]         tag_sel,   // own tag when selected, else zero
  output logic                match      // tag equals key
);
  logic        used_r, used_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic        sh_r, sh_nxt;

  assign match   = (tag_r == key);
  assign tag_sel = sel ? tag_r : 32'd0;
  assign sh_out  = sh_r;

  always_comb begin
    used_nxt = used_r;
    tag_nxt  = tag_r;
    sh_nxt   = sh_r;
    if (cmd.clr) begin
      used_nxt = 1'b0;
      tag_nxt  = 32'd0;
    end else if (cmd.do_free && match) begin
      used_nxt = 1'b0;
    end else if (cmd.do_mark && in_range) begin
      used_nxt = 1'b1;
      tag_nxt  = new_tag;
    end
    if (load) sh_nxt = used_r;
    else if (shift) sh_nxt = sh_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      tag_r  <= 32'd0;
      sh_r   <= 1'b1;
    end else begin
      used_r <= used_nxt;
      tag_r  <= tag_nxt;
      sh_r   <= sh_nxt;
    end
  end
endmodule

@@ rtl/first_fit_block_allocator_core.sv @@
// Top level: first-fit contiguous block allocator over a chain of block cells.
// After a request transfers, a tag state reads the addressed block's tag into
// a key. Allocate then walks the used bits of the cells through a shift chain,
// one block per cycle, and stops at the first run that fits or after the last
// block; count walks all NUM_BLOCKS match bits the same way and sums them one
// per cycle. An apply state then applies the change to the cells and registers
// the result. An allocate of zero size or of more than the pool skips the walk
// and the apply state and registers its result in the tag state; free, count
// outside the pool and the unused code skip only the walk; count inside the
// pool always walks all blocks. The result sits in an output register until
// transferred; the next request transfers at the earliest in the cycle after
// that. The block size is the package constant BLOCK_BYTES_DEF and must be a
// power of two. The user must write heap_base through the cfg channel only
// while idle; the block itself does not enforce this.
module first_fit_block_allocator_core #(
  parameter int NUM_BLOCKS  = ffba_pkg::NUM_BLOCKS_DEF
) (
  input logic clk,
  input logic rst_n,
  ffba_req_if.sink   in_ch,
  ffba_rsp_if.source out_ch,
  ffba_cfg_if.sink   cfg_ch
);
  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int CW = IW + 1;
  localparam int SH = $clog2(ffba_pkg::BLOCK_BYTES_DEF);
  localparam int BB = 1 << SH;

  // Configuration: always ready, write the base on each transfer.
  logic [31:0] heap_base_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) heap_base_r <= 32'd0;
    else if (cfg_ch.valid) heap_base_r <= cfg_ch.data;
  end

  ffba_pkg::state_t state_r, state_nxt;
  logic [1:0]  op_r;
  logic [32:0] need_r;
  logic        inpool_r;
  logic [IW-1:0] idx_r;
  logic        addr_zero_r;
  logic [31:0] tag_in_r, key_r;
  logic [CW-1:0] pos_r, run_r, start_r, cnt_r;
  logic        found_r;
  logic [31:0] res_addr_r;
  logic [1:0]  status_r;
  logic [8:0]  bcount_r;

  // Request decode at the transfer.
  logic [32:0] off_w;
  logic [32:0] need_w;
  logic        inpool_w;
  assign off_w   = {1'b0, in_ch.address} - {1'b0, heap_base_r};
  assign need_w  = ({1'b0, in_ch.size_bytes} + 33'(BB - 1)) >> SH;
  assign inpool_w = !off_w[32] && ((off_w >> SH) < 33'(NUM_BLOCKS));

  // Cell chain.
  ffba_pkg::cell_cmd_t cmd;
  logic [NUM_BLOCKS-1:0] sh_o, match_w, rng_w, sel_w;
  logic [31:0] tsel [NUM_BLOCKS];
  logic [31:0] tag_or;
  logic load_w, shift_w;

  genvar g;
  generate
    for (g = 0; g < NUM_BLOCKS; g++) begin : g_cell
      assign sel_w[g] = (idx_r == IW'(g));
      assign rng_w[g] = (CW'(g) >= start_r) && ({1'b0, CW'(g)} < {1'b0, start_r} + need_r[CW:0]);
      ffba_cell u_cell (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sel(sel_w[g]), .key(key_r),
        .in_range(rng_w[g]), .new_tag(tag_in_r), .load(load_w), .shift(shift_w),
        .sh_in((g == NUM_BLOCKS-1) ? 1'b1 : sh_o[(g+1) % NUM_BLOCKS]),
        .sh_out(sh_o[g]), .tag_sel(tsel[g]), .match(match_w[g])
      );
    end
  endgenerate

  // Tag readout: each cell drives zero unless selected; OR them together.
  always_comb begin
    tag_or = 32'd0;
    for (int i = 0; i < NUM_BLOCKS; i++) tag_or = tag_or | tsel[i];
  end

  // Shift register for match bits to sum one per cycle.
  logic [NUM_BLOCKS-1:0] msh_r;
  logic head_used, head_match;
  assign head_used  = sh_o[0];
  assign head_match = msh_r[0];

  assign in_ch.ready    = (state_r == ffba_pkg::S_IDLE);
  assign out_ch.valid   = (state_r == ffba_pkg::S_OUT);
  assign out_ch.result_address = res_addr_r;
  assign out_ch.status  = status_r;
  assign out_ch.block_count = bcount_r;

  logic [CW-1:0] run_inc;
  assign run_inc = run_r + CW'(1);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    load_w      = 1'b0;
    shift_w     = 1'b0;
    case (state_r)
      ffba_pkg::S_IDLE:  if (in_ch.valid) state_nxt = ffba_pkg::S_TAG;
      ffba_pkg::S_TAG: begin
        // Latch key, load the used-bit scan chain; start walk, apply or finish.
        load_w = 1'b1;
        if (op_r == ffba_pkg::OP_ALLOC) begin
          state_nxt = (need_r == 33'd0 || need_r > 33'(NUM_BLOCKS)) ?
                      ffba_pkg::S_OUT : ffba_pkg::S_SCAN;
        end else if (op_r == ffba_pkg::OP_COUNT && inpool_r) begin
          state_nxt = ffba_pkg::S_SCAN;
        end else begin
          state_nxt = ffba_pkg::S_APPLY;
        end
      end
      ffba_pkg::S_SCAN: begin
        shift_w = 1'b1;
        if (pos_r == CW'(NUM_BLOCKS - 1) ||
            (op_r == ffba_pkg::OP_ALLOC && !head_used && {{(33-CW){1'b0}}, run_inc} == need_r))
          state_nxt = ffba_pkg::S_APPLY;
      end
      ffba_pkg::S_APPLY: begin
        if (op_r == ffba_pkg::OP_FREE) cmd.do_free = inpool_r && !addr_zero_r;
        if (op_r == ffba_pkg::OP_ALLOC) cmd.do_mark = found_r;
        state_nxt = ffba_pkg::S_OUT;
      end
      ffba_pkg::S_OUT: if (out_ch.ready) state_nxt = ffba_pkg::S_IDLE;
      default: state_nxt = ffba_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ffba_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  logic [CW-1:0] cnt_inc;
  assign cnt_inc = cnt_r + CW'(head_match);

  always_ff @(posedge clk) begin
    case (state_r)
      ffba_pkg::S_IDLE: if (in_ch.valid) begin
        op_r        <= in_ch.operation;
        need_r      <= need_w;
        inpool_r    <= inpool_w;
        idx_r       <= IW'(off_w >> SH);
        addr_zero_r <= (in_ch.address == 32'd0);
        tag_in_r    <= in_ch.tag;
        pos_r       <= '0;
        run_r       <= '0;
        start_r     <= '0;
        cnt_r       <= '0;
        found_r     <= 1'b0;
      end
      ffba_pkg::S_TAG: begin
        key_r <= tag_or;
        msh_r <= '0;
        // Zero size or larger than the pool: answer without a walk.
        if (op_r == ffba_pkg::OP_ALLOC && (need_r == 33'd0 || need_r > 33'(NUM_BLOCKS))) begin
          res_addr_r <= 32'd0;
          bcount_r   <= 9'd0;
          status_r   <= ffba_pkg::ST_NOFIT;
        end
      end
      ffba_pkg::S_SCAN: begin
        pos_r <= pos_r + CW'(1);
        // Capture match bits on the first walk cycle, then advance them.
        if (pos_r == '0) begin
          msh_r <= {1'b0, match_w[NUM_BLOCKS-1:1]};
          cnt_r <= CW'(match_w[0]);
        end else begin
          msh_r <= {1'b0, msh_r[NUM_BLOCKS-1:1]};
          cnt_r <= cnt_inc;
        end
        if (head_used) begin
          run_r   <= '0;
          start_r <= pos_r + CW'(1);
        end else begin
          run_r <= run_inc;
          if ({{(33-CW){1'b0}}, run_inc} == need_r) found_r <= 1'b1;
        end
      end
      ffba_pkg::S_APPLY: begin
        case (op_r)
          ffba_pkg::OP_ALLOC: begin
            res_addr_r <= found_r ? heap_base_r + (32'(start_r) << SH) : 32'd0;
            status_r   <= found_r ? ffba_pkg::ST_OK : ffba_pkg::ST_NOFIT;
            bcount_r   <= 9'd0;
          end
          ffba_pkg::OP_FREE: begin
            res_addr_r <= 32'd0;
            bcount_r   <= 9'd0;
            status_r   <= (!addr_zero_r && !inpool_r) ? ffba_pkg::ST_OUTSIDE : ffba_pkg::ST_OK;
          end
          ffba_pkg::OP_COUNT: begin
            res_addr_r <= 32'd0;
            status_r   <= inpool_r ? ffba_pkg::ST_OK : ffba_pkg::ST_OUTSIDE;
            if (!inpool_r) bcount_r <= 9'd0;
            else bcount_r <= (cnt_r > CW'(511)) ? 9'd511 : 9'(cnt_r);
          end
          default: begin
            res_addr_r <= 32'd0;
            bcount_r   <= 9'd0;
            status_r   <= ffba_pkg::ST_OK;
          end
        endcase
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffba_pkg::S_SCAN) |-> (op_r == ffba_pkg::OP_ALLOC || op_r == ffba_pkg::OP_COUNT))
    else $error("scan entered for a request that needs no walk");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ffba_pkg::S_TAG))
    else $error("transfer did not start tag lookup");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(status_r) && $stable(res_addr_r))
    else $error("result changed while stalled");
endmodule
